/* rtl/rrpt_pkg.sv */
// rrpt_pkg: shared types and codes of the round-robin process table
`timescale 1ns / 1ps

package rrpt_pkg;

  localparam int unsigned CtxW   = 32;
  localparam int unsigned PidOutW = 16;

  // operation selector
  typedef enum logic [2:0] {
    FN_ADD      = 3'd0,
    FN_SCHEDULE = 3'd1,
    FN_FORK     = 3'd2,
    FN_EXIT     = 3'd3,
    FN_WAIT     = 3'd4
  } func_e;

  // per-entry task state
  typedef enum logic [1:0] {
    ES_READY      = 2'd0,
    ES_RUNNING    = 2'd1,
    ES_BLOCKED    = 2'd2,
    ES_TERMINATED = 2'd3
  } entry_state_e;

  // result status codes
  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_FULL   = 2'd1,
    RES_NO_CUR = 2'd2
  } res_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CUR_RD,
    S_CUR_MOD,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]          func;
    logic [CtxW-1:0]     context_req;
    logic [PidOutW-1:0]  new_parent_pid;
    logic [PidOutW-1:0]  query_pid;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CtxW-1:0]     context_out;
    logic [PidOutW-1:0]  pid_out;
    logic                all_terminated;
  } rsp_t;

endpackage

/* rtl/round_robin_process_table_core.sv */
// round_robin_process_table_core: process table sequencer around the entry memory
// add, fork and unused codes: result in S_RESP, the state that follows S_DISPATCH.
// schedule, exit and wait: schedule and exit may first update the current entry (S_CUR_RD, S_CUR_MOD);
// the scan (S_SCAN) reads one table entry per cycle through the single read port of the memory.
// busy stays high from accept until the result cycle ends; results cannot be held off.
// reset clears counters and the current task; table contents stay undefined.
`timescale 1ns / 1ps

module round_robin_process_table_core #(
  parameter int unsigned MAX_TASKS = 256,
  parameter int unsigned PID_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rrpt_pkg::req_t req_i,
  output logic          done_o,
  output rrpt_pkg::rsp_t rsp_o
);

  localparam int unsigned AW  = $clog2(MAX_TASKS);
  localparam int unsigned CW  = $clog2(MAX_TASKS + 1);
  localparam int unsigned CXW = CW + 1;
  localparam int unsigned PW  = PID_BITS;
  localparam int unsigned XW  = PID_BITS + rrpt_pkg::PidOutW;
  localparam int unsigned CTXW = rrpt_pkg::CtxW;
  // memory word: pid | parent | state | context
  localparam int unsigned ST_LO  = CTXW;
  localparam int unsigned PAR_LO = CTXW + 2;
  localparam int unsigned PID_LO = CTXW + 2 + PW;
  localparam int unsigned WW     = CTXW + 2 + 2 * PW;

  rrpt_pkg::state_e state_q, state_d;
  rrpt_pkg::req_t   req_q, req_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] live_q, live_d;
  logic          cur_valid_q, cur_valid_d;
  logic [AW-1:0] cur_slot_q, cur_slot_d;
  logic [PW-1:0] cur_pid_q, cur_pid_d;
  logic [PW-1:0] pid_ctr_q, pid_ctr_d;

  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [CW-1:0] scan_rem_q, scan_rem_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;
  logic          chk_vld_q, chk_vld_d;

  logic [1:0]                    res_status_q, res_status_d;
  logic [CTXW-1:0]               res_ctx_q, res_ctx_d;
  logic [PW-1:0]                 res_pid_q, res_pid_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  logic [PW-1:0]   rd_pid;
  logic [PW-1:0]   rd_parent;
  logic [1:0]      rd_state;
  logic [CTXW-1:0] rd_ctx;

  logic          accept;
  logic          full;
  logic          cur_ok;
  logic          is_sched;
  logic          is_wait;
  logic          wait_match;
  logic          found;
  logic          scan_end;
  logic [PW-1:0] npar_pid;
  logic [XW-1:0] qpid_x;
  logic [XW-1:0] rdpid_x;
  logic [XW-1:0] respid_x;

  rrpt_mem #(
    .Width (WW),
    .Depth (MAX_TASKS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next slot in round-robin order, wrapping at the fill count
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] cnt);
    logic [CXW-1:0] inc;
    inc = CXW'(idx) + CXW'(1);
    if (inc == CXW'(cnt)) begin
      next_slot = '0;
    end else begin
      next_slot = inc[AW-1:0];
    end
  endfunction

  assign rd_pid    = mem_rdata[PID_LO +: PW];
  assign rd_parent = mem_rdata[PAR_LO +: PW];
  assign rd_state  = mem_rdata[ST_LO +: 2];
  assign rd_ctx    = mem_rdata[CTXW-1:0];

  assign accept   = start && !busy;
  assign full     = (count_q == CW'(MAX_TASKS));
  assign cur_ok   = cur_valid_q && (CXW'(cur_slot_q) < CXW'(count_q));
  assign is_sched = (req_q.func == rrpt_pkg::FN_SCHEDULE);
  assign is_wait  = (req_q.func == rrpt_pkg::FN_WAIT);

  // pids are compared and truncated through a common wide form
  assign npar_pid   = PW'(req_q.new_parent_pid);
  assign qpid_x     = XW'(req_q.query_pid);
  assign rdpid_x    = XW'(rd_pid);
  assign wait_match = (rdpid_x == qpid_x) && (rd_parent == cur_pid_q);

  assign found = chk_vld_q && ((is_sched && rd_state == rrpt_pkg::ES_READY) ||
                               (is_wait && wait_match));
  assign scan_end = found || (!chk_vld_q && scan_rem_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrpt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = rrpt_pkg::S_DISPATCH;
        end
      end
      rrpt_pkg::S_DISPATCH: begin
        state_d = rrpt_pkg::S_RESP;
        case (req_q.func)
          rrpt_pkg::FN_SCHEDULE: begin
            if (count_q != '0) begin
              state_d = cur_ok ? rrpt_pkg::S_CUR_RD : rrpt_pkg::S_SCAN;
            end
          end
          rrpt_pkg::FN_EXIT: begin
            if (cur_ok) begin
              state_d = rrpt_pkg::S_CUR_RD;
            end
          end
          rrpt_pkg::FN_WAIT: begin
            if (cur_ok) begin
              state_d = rrpt_pkg::S_SCAN;
            end
          end
          default: state_d = rrpt_pkg::S_RESP;
        endcase
      end
      rrpt_pkg::S_CUR_RD:  state_d = rrpt_pkg::S_CUR_MOD;
      rrpt_pkg::S_CUR_MOD: state_d = rrpt_pkg::S_SCAN;
      rrpt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = rrpt_pkg::S_RESP;
        end
      end
      rrpt_pkg::S_RESP: state_d = rrpt_pkg::S_IDLE;
      default:          state_d = rrpt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d        = req_q;
    count_d      = count_q;
    live_d       = live_q;
    cur_valid_d  = cur_valid_q;
    cur_slot_d   = cur_slot_q;
    cur_pid_d    = cur_pid_q;
    pid_ctr_d    = pid_ctr_q;
    scan_idx_d   = scan_idx_q;
    scan_rem_d   = scan_rem_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = 1'b0;
    res_status_d = res_status_q;
    res_ctx_d    = res_ctx_q;
    res_pid_d    = res_pid_q;
    mem_we       = 1'b0;
    mem_waddr    = chk_idx_q;
    mem_wdata    = mem_rdata;
    mem_raddr    = scan_idx_q;

    case (state_q)
      rrpt_pkg::S_IDLE: begin
        if (accept) begin
          req_d = req_i;
        end
      end
      rrpt_pkg::S_DISPATCH: begin
        res_status_d = rrpt_pkg::RES_OK;
        res_ctx_d    = '0;
        res_pid_d    = '0;
        scan_idx_d   = '0;
        scan_rem_d   = count_q;
        case (req_q.func)
          rrpt_pkg::FN_ADD, rrpt_pkg::FN_FORK: begin
            if (full) begin
              res_status_d = rrpt_pkg::RES_FULL;
            end else if (req_q.func == rrpt_pkg::FN_FORK && !cur_ok) begin
              res_status_d = rrpt_pkg::RES_NO_CUR;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[AW-1:0];
              mem_wdata = {pid_ctr_q,
                           (req_q.func == rrpt_pkg::FN_ADD) ? npar_pid : cur_pid_q,
                           rrpt_pkg::ES_READY, req_q.context_req};
              res_pid_d = pid_ctr_q;
              pid_ctr_d = pid_ctr_q + PW'(1);
              count_d   = count_q + CW'(1);
              // entry 0 never counts towards the live total
              if (count_q != '0) begin
                live_d = live_q + CW'(1);
              end
            end
          end
          rrpt_pkg::FN_SCHEDULE: begin
            res_ctx_d = req_q.context_req;
          end
          rrpt_pkg::FN_EXIT, rrpt_pkg::FN_WAIT: begin
            if (!cur_ok) begin
              res_status_d = rrpt_pkg::RES_NO_CUR;
            end
          end
          default: res_status_d = rrpt_pkg::RES_OK;
        endcase
      end
      rrpt_pkg::S_CUR_RD: begin
        mem_raddr = cur_slot_q;
      end
      rrpt_pkg::S_CUR_MOD: begin
        mem_waddr  = cur_slot_q;
        scan_rem_d = count_q;
        if (is_sched) begin
          // park the running task with the saved context
          scan_idx_d = next_slot(cur_slot_q, count_q);
          if (rd_state == rrpt_pkg::ES_RUNNING) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_pid, rd_parent, rrpt_pkg::ES_READY, req_q.context_req};
          end
        end else begin
          scan_idx_d = '0;
          mem_we     = 1'b1;
          mem_wdata  = {rd_pid, rd_parent, rrpt_pkg::ES_TERMINATED, rd_ctx};
          if (cur_slot_q != '0 && rd_state != rrpt_pkg::ES_TERMINATED) begin
            live_d = live_q - CW'(1);
          end
        end
      end
      rrpt_pkg::S_SCAN: begin
        mem_raddr = scan_idx_q;
        if (scan_rem_q != '0 && !found) begin
          chk_vld_d  = 1'b1;
          chk_idx_d  = scan_idx_q;
          scan_idx_d = next_slot(scan_idx_q, count_q);
          scan_rem_d = scan_rem_q - CW'(1);
        end
        if (chk_vld_q) begin
          mem_waddr = chk_idx_q;
          if (is_sched) begin
            if (found) begin
              mem_we      = 1'b1;
              mem_wdata   = {rd_pid, rd_parent, rrpt_pkg::ES_RUNNING, rd_ctx};
              cur_valid_d = 1'b1;
              cur_slot_d  = chk_idx_q;
              cur_pid_d   = rd_pid;
              res_ctx_d   = rd_ctx;
            end
          end else if (is_wait) begin
            if (found && rd_state == rrpt_pkg::ES_TERMINATED) begin
              res_pid_d = PW'(qpid_x);
            end
          end else if (rd_parent == cur_pid_q) begin
            // orphans go to pid 0
            mem_we    = 1'b1;
            mem_wdata = {rd_pid, {PW{1'b0}}, rd_state, rd_ctx};
          end
        end
      end
      default: begin
        chk_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrpt_pkg::S_IDLE;
      count_q     <= '0;
      live_q      <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      cur_pid_q   <= '0;
      pid_ctr_q   <= '0;
      chk_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      live_q      <= live_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      cur_pid_q   <= cur_pid_d;
      pid_ctr_q   <= pid_ctr_d;
      chk_vld_q   <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    scan_idx_q   <= scan_idx_d;
    scan_rem_q   <= scan_rem_d;
    chk_idx_q    <= chk_idx_d;
    res_status_q <= res_status_d;
    res_ctx_q    <= res_ctx_d;
    res_pid_q    <= res_pid_d;
  end

  assign respid_x = XW'(res_pid_q);

  assign busy                 = (state_q != rrpt_pkg::S_IDLE);
  assign done_o               = (state_q == rrpt_pkg::S_RESP);
  assign rsp_o.status         = res_status_q;
  assign rsp_o.context_out    = res_ctx_q;
  assign rsp_o.pid_out        = respid_x[rrpt_pkg::PidOutW-1:0];
  assign rsp_o.all_terminated = (live_q == '0);

  a_live_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q < count_q || live_q == '0)
    else $error("live count exceeds table fill");

  a_cur_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (CXW'(cur_slot_q) < CXW'(count_q)))
    else $error("current slot outside the table");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("accepted item did not hold the sequencer");

  a_scan_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rrpt_pkg::S_SCAN) |-> !chk_vld_q || $past(state_q) == rrpt_pkg::S_SCAN)
    else $error("scan check stage left valid outside a scan");

endmodule

/* rtl/rrpt_mem.sv */
// rrpt_mem: single-port-write table memory with registered read data
`timescale 1ns / 1ps

module rrpt_mem #(
  parameter int unsigned Width = 66,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
